@@ rtl/lscc_pkg.sv @@
// Package for the line sensor calibration and centroid block.
// Holds the state, command and status types, the reset tables and shared widths.
// No dependencies.
package lscc_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int GAIN_W     = 25;
  localparam int WEIGHT_W   = 16;
  localparam int MAX_CH     = 16;
  localparam int DIVIDEND_W = 30;
  localparam int DIVISOR_W  = 15;
  localparam int TORQUE_W   = 32;
  localparam int MASS_W     = 15;

  localparam logic [GAIN_W-1:0]   GAIN_MAX  = 25'd16777216;
  localparam logic [SAMPLE_W-1:0] LEVEL_MAX = 12'd4095;

  localparam logic [1:0] OP_LEARN   = 2'd0;
  localparam logic [1:0] OP_DERIVE  = 2'd1;
  localparam logic [1:0] OP_MEASURE = 2'd2;

  localparam logic [2:0] REG_WEIGHT_A  = 3'd0;
  localparam logic [2:0] REG_WEIGHT_B  = 3'd1;
  localparam logic [2:0] REG_WEIGHT_C  = 3'd2;
  localparam logic [2:0] REG_WEIGHT_D  = 3'd3;
  localparam logic [2:0] REG_WEIGHT_E  = 3'd4;
  localparam logic [2:0] REG_THRESHOLD = 3'd5;

  localparam logic [SAMPLE_W-1:0] FLOOR_RESET [MAX_CH] = '{
    12'd344, 12'd216, 12'd212, 12'd240, 12'd240, 12'd228, 12'd124,
    12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0};

  localparam logic [GAIN_W-1:0] GAIN_RESET [MAX_CH] = '{
    25'd5256, 25'd5287, 25'd5467, 25'd5191, 25'd5924, 25'd5246, 25'd4225,
    25'd4096, 25'd4096, 25'd4096, 25'd4096, 25'd4096, 25'd4096, 25'd4096,
    25'd4096, 25'd4096};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_LEARN,
    ST_GAIN_START,
    ST_GAIN_WAIT,
    ST_CAL_MUL,
    ST_CAL_SAT,
    ST_ACC_MUL,
    ST_ACC_ADD,
    ST_POS_START,
    ST_POS_WAIT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic in_load;
    logic learn;
    logic ch_clr;
    logic ch_inc;
    logic gain_start;
    logic gain_write;
    logic cal_mul;
    logic cal_sat;
    logic acc_clr;
    logic acc_mul;
    logic acc_add;
    logic pos_start;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       ch_last;
    logic       acc_last;
    logic       div_done;
    logic       out_free;
  } status_t;

endpackage

@@ rtl/lscc_divider.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Shared by the gain derivation and the centroid; uses lscc_pkg widths.
module lscc_divider (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [lscc_pkg::DIVIDEND_W-1:0]     dividend,
  input  logic [lscc_pkg::DIVISOR_W-1:0]      divisor,
  output logic [lscc_pkg::DIVIDEND_W-1:0]     quotient,
  output logic                                done
);

  localparam int CNT_W = $clog2(lscc_pkg::DIVIDEND_W + 1);

  logic [CNT_W-1:0]                  count;
  logic [lscc_pkg::DIVISOR_W:0]      rem;
  logic [lscc_pkg::DIVIDEND_W-1:0]   quo;
  logic [lscc_pkg::DIVISOR_W-1:0]    dvs;
  logic [lscc_pkg::DIVISOR_W:0]      rem_shift;
  logic [lscc_pkg::DIVISOR_W:0]      rem_sub;
  logic                              fits;

  // The divisor is held from the start pulse, since the caller's operands move on.
  always_comb begin
    rem_shift = {rem[lscc_pkg::DIVISOR_W-1:0], quo[lscc_pkg::DIVIDEND_W-1]};
    fits      = rem_shift >= {1'b0, dvs};
    rem_sub   = rem_shift - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else if (start) begin
      count <= CNT_W'(lscc_pkg::DIVIDEND_W);
      done  <= 1'b0;
    end else if (count != '0) begin
      count <= count - 1'b1;
      done  <= (count == CNT_W'(1));
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (count != '0) begin
      rem <= fits ? rem_sub : rem_shift;
      quo <= {quo[lscc_pkg::DIVIDEND_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

@@ rtl/lscc_datapath.sv @@
// Datapath: sample capture, calibration state, configuration registers, accumulators
// and the output register. Uses lscc_pkg and instantiates lscc_divider.
module lscc_datapath #(
  parameter int CHANNELS  = 7,
  parameter int S_TDATA_W = 88,
  parameter int M_TDATA_W = 104
) (
  input  logic                   clk,
  input  logic                   rst,
  input  lscc_pkg::cmd_t         cmd,
  output lscc_pkg::status_t      status,
  input  logic [S_TDATA_W-1:0]   s_tdata,
  input  logic [1:0]             s_tuser,
  input  logic                   cfg_valid,
  input  logic [2:0]             cfg_index,
  input  logic [15:0]            cfg_data,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [M_TDATA_W-1:0]   m_tdata,
  output logic [1:0]             m_tuser
);

  localparam int CW = $clog2(CHANNELS);
  localparam int SW = lscc_pkg::SAMPLE_W;
  localparam int PW = SW + lscc_pkg::GAIN_W;
  localparam int TPW = lscc_pkg::WEIGHT_W + SW + 1;

  logic [1:0]                    op;
  logic [SW-1:0]                 sample [CHANNELS];
  logic [SW-1:0]                 floor_level [CHANNELS];
  logic [SW-1:0]                 peak_level [CHANNELS];
  logic [lscc_pkg::GAIN_W-1:0]   channel_gain [CHANNELS];
  logic [SW-1:0]                 level [CHANNELS];
  logic signed [lscc_pkg::WEIGHT_W-1:0] weight [5];
  logic [SW-1:0]                 center_threshold;
  logic [CW-1:0]                 ch;
  logic [PW-1:0]                 prod;
  logic signed [TPW-1:0]         tprod;
  logic signed [lscc_pkg::TORQUE_W-1:0] torque;
  logic [lscc_pkg::MASS_W-1:0]   mass;

  logic [SW-1:0]                 diff;
  logic [SW-1:0]                 cal_level;
  logic [SW-1:0]                 span;
  logic [lscc_pkg::TORQUE_W-1:0] torque_mag;
  logic                          div_start;
  logic [lscc_pkg::DIVIDEND_W-1:0] div_dividend;
  logic [lscc_pkg::DIVISOR_W-1:0]  div_divisor;
  logic [lscc_pkg::DIVIDEND_W-1:0] div_quotient;
  logic                          div_done;
  logic signed [15:0]            position;
  logic                          centered;
  logic [M_TDATA_W-1:0]          out_word;

  always_comb begin
    diff      = (sample[ch] > floor_level[ch]) ? sample[ch] - floor_level[ch] : '0;
    cal_level = (prod[PW-1:12] > (PW-12)'(lscc_pkg::LEVEL_MAX)) ? lscc_pkg::LEVEL_MAX
              : prod[23:12];
    span      = peak_level[ch] - floor_level[ch];
    torque_mag = torque[lscc_pkg::TORQUE_W-1] ? -torque : torque;
  end

  always_comb begin
    div_start = cmd.gain_start | cmd.pos_start;
    if (cmd.gain_start) begin
      div_dividend = lscc_pkg::DIVIDEND_W'(lscc_pkg::GAIN_MAX);
      div_divisor  = lscc_pkg::DIVISOR_W'(span);
    end else begin
      div_dividend = torque_mag[lscc_pkg::DIVIDEND_W-1:0];
      div_divisor  = mass;
    end
  end

  lscc_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quotient),
    .done     (div_done)
  );

  // Saturate the centroid quotient to 16 bits after restoring the sign.
  always_comb begin
    if (mass == '0) begin
      position = '0;
    end else if (torque[lscc_pkg::TORQUE_W-1]) begin
      position = (div_quotient > 30'd32768) ? 16'sh8000 : -$signed(div_quotient[15:0]);
    end else begin
      position = (div_quotient > 30'd32767) ? 16'sh7fff : $signed(div_quotient[15:0]);
    end
    centered = (level[3] > center_threshold) && (level[2] < center_threshold)
            && (level[4] < center_threshold);
  end

  always_comb begin
    out_word = '0;
    out_word[15:0] = position;
    for (int i = 0; i < CHANNELS; i++) begin
      out_word[16 + SW*i +: SW] = level[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      op <= s_tuser;
      for (int i = 0; i < CHANNELS; i++) begin
        sample[i] <= s_tdata[SW*i +: SW];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        floor_level[i]  <= lscc_pkg::FLOOR_RESET[i];
        peak_level[i]   <= '0;
        channel_gain[i] <= lscc_pkg::GAIN_RESET[i];
      end
    end else begin
      if (cmd.learn) begin
        for (int i = 0; i < CHANNELS; i++) begin
          if (peak_level[i] < sample[i]) peak_level[i] <= sample[i];
          if (floor_level[i] > sample[i]) floor_level[i] <= sample[i];
        end
      end
      if (cmd.gain_write) begin
        channel_gain[ch] <= (peak_level[ch] > floor_level[ch])
                          ? div_quotient[lscc_pkg::GAIN_W-1:0] : lscc_pkg::GAIN_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      weight[0]        <= -16'sd2;
      weight[1]        <= -16'sd1;
      weight[2]        <= 16'sd0;
      weight[3]        <= 16'sd1;
      weight[4]        <= 16'sd2;
      center_threshold <= 12'd2048;
    end else if (cfg_valid) begin
      case (cfg_index)
        lscc_pkg::REG_WEIGHT_A:  weight[0] <= $signed(cfg_data);
        lscc_pkg::REG_WEIGHT_B:  weight[1] <= $signed(cfg_data);
        lscc_pkg::REG_WEIGHT_C:  weight[2] <= $signed(cfg_data);
        lscc_pkg::REG_WEIGHT_D:  weight[3] <= $signed(cfg_data);
        lscc_pkg::REG_WEIGHT_E:  weight[4] <= $signed(cfg_data);
        lscc_pkg::REG_THRESHOLD: center_threshold <= cfg_data[SW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ch <= '0;
    end else if (cmd.ch_clr) begin
      ch <= '0;
    end else if (cmd.ch_inc) begin
      ch <= ch + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cal_mul) prod <= PW'(diff) * PW'(channel_gain[ch]);
    if (cmd.cal_sat) level[ch] <= cal_level;
    if (cmd.acc_mul) begin
      tprod <= TPW'(weight[ch[2:0]]) * $signed({1'b0, level[CW'(ch + 1'b1)]});
    end
    if (cmd.acc_clr) begin
      mass   <= '0;
      torque <= '0;
    end else begin
      if (cmd.cal_sat && ch >= CW'(1) && ch <= CW'(5)) begin
        mass <= mass + lscc_pkg::MASS_W'(cal_level);
      end
      if (cmd.acc_add) torque <= torque + lscc_pkg::TORQUE_W'(tprod);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= out_word;
      m_tuser <= {centered, (mass == '0)};
    end
  end

  always_comb begin
    status.op       = op;
    status.ch_last  = (ch == CW'(CHANNELS - 1));
    status.acc_last = (ch == CW'(4));
    status.div_done = div_done;
    status.out_free = ~m_tvalid | m_tready;
  end

endmodule

@@ rtl/lscc_ctrl.sv @@
// Controller state machine that sequences learn, derive and measure requests.
// Uses lscc_pkg types; drives the datapath through cmd_t and reads status_t.
module lscc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  lscc_pkg::status_t   status,
  output lscc_pkg::cmd_t      cmd
);

  lscc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= lscc_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      lscc_pkg::ST_IDLE:       if (s_tvalid) state_next = lscc_pkg::ST_DECODE;
      lscc_pkg::ST_DECODE: begin
        case (status.op)
          lscc_pkg::OP_LEARN:   state_next = lscc_pkg::ST_LEARN;
          lscc_pkg::OP_DERIVE:  state_next = lscc_pkg::ST_GAIN_START;
          lscc_pkg::OP_MEASURE: state_next = lscc_pkg::ST_CAL_MUL;
          default:              state_next = lscc_pkg::ST_IDLE;
        endcase
      end
      lscc_pkg::ST_LEARN:      state_next = lscc_pkg::ST_IDLE;
      lscc_pkg::ST_GAIN_START: state_next = lscc_pkg::ST_GAIN_WAIT;
      lscc_pkg::ST_GAIN_WAIT: begin
        if (status.div_done) begin
          state_next = status.ch_last ? lscc_pkg::ST_IDLE : lscc_pkg::ST_GAIN_START;
        end
      end
      lscc_pkg::ST_CAL_MUL:    state_next = lscc_pkg::ST_CAL_SAT;
      lscc_pkg::ST_CAL_SAT:
        state_next = status.ch_last ? lscc_pkg::ST_ACC_MUL : lscc_pkg::ST_CAL_MUL;
      lscc_pkg::ST_ACC_MUL:    state_next = lscc_pkg::ST_ACC_ADD;
      lscc_pkg::ST_ACC_ADD:
        state_next = status.acc_last ? lscc_pkg::ST_POS_START : lscc_pkg::ST_ACC_MUL;
      lscc_pkg::ST_POS_START:  state_next = lscc_pkg::ST_POS_WAIT;
      lscc_pkg::ST_POS_WAIT:   if (status.div_done) state_next = lscc_pkg::ST_EMIT;
      lscc_pkg::ST_EMIT:       if (status.out_free) state_next = lscc_pkg::ST_IDLE;
      default:                 state_next = lscc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      lscc_pkg::ST_IDLE: begin
        s_tready    = 1'b1;
        cmd.in_load = s_tvalid;
      end
      lscc_pkg::ST_DECODE: begin
        cmd.ch_clr  = 1'b1;
        cmd.acc_clr = 1'b1;
      end
      lscc_pkg::ST_LEARN:      cmd.learn = 1'b1;
      lscc_pkg::ST_GAIN_START: cmd.gain_start = 1'b1;
      lscc_pkg::ST_GAIN_WAIT: begin
        cmd.gain_write = status.div_done;
        cmd.ch_inc     = status.div_done & ~status.ch_last;
      end
      lscc_pkg::ST_CAL_MUL:    cmd.cal_mul = 1'b1;
      lscc_pkg::ST_CAL_SAT: begin
        cmd.cal_sat = 1'b1;
        cmd.ch_clr  = status.ch_last;
        cmd.ch_inc  = ~status.ch_last;
      end
      lscc_pkg::ST_ACC_MUL:    cmd.acc_mul = 1'b1;
      lscc_pkg::ST_ACC_ADD: begin
        cmd.acc_add = 1'b1;
        cmd.ch_inc  = ~status.acc_last;
      end
      lscc_pkg::ST_POS_START:  cmd.pos_start = 1'b1;
      lscc_pkg::ST_POS_WAIT:   ;
      lscc_pkg::ST_EMIT:       cmd.out_load = status.out_free;
      default:                 ;
    endcase
  end

endmodule

@@ rtl/line_sensor_calibrate_centroid.sv @@
// Line sensor calibration and centroid, top level: controller plus datapath.
// One request at a time. Learn updates the peak and floor tables; derive runs, per channel,
// a start step and a 30-step pass of the shared divider to form the gain; measure
// calibrates each channel, accumulates the weighted sum and forms the centroid with the
// same divider; the result is emitted once the output is free, later while one still waits.
// Synchronous reset loads the preset floor and gain tables, clears the peaks and
// restores the default weights and threshold.
module line_sensor_calibrate_centroid #(
  parameter int CHANNELS = 7
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      s_tvalid,
  output logic                                      s_tready,
  // sample_0 .. sample_{CHANNELS-1}, 12 bits each, zero padded to bytes
  input  logic [((12*CHANNELS+7)/8)*8-1:0]          s_tdata,
  // opcode
  input  logic [1:0]                                s_tuser,
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic [2:0]                                cfg_index,
  input  logic [15:0]                               cfg_data,
  output logic                                      m_tvalid,
  input  logic                                      m_tready,
  // line_position (16), level_0 .. level_{CHANNELS-1} (12 each), zero padded
  output logic [((16+12*CHANNELS+7)/8)*8-1:0]       m_tdata,
  // no_line, centered
  output logic [1:0]                                m_tuser
);

  localparam int S_TDATA_W = ((12*CHANNELS+7)/8)*8;
  localparam int M_TDATA_W = ((16+12*CHANNELS+7)/8)*8;

  lscc_pkg::cmd_t    cmd;
  lscc_pkg::status_t status;

  assign cfg_ready = 1'b1;

  lscc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  lscc_datapath #(
    .CHANNELS  (CHANNELS),
    .S_TDATA_W (S_TDATA_W),
    .M_TDATA_W (M_TDATA_W)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule
